[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the MIDI encoder.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scm assertion failed");
`define SCM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("scm forbidden condition seen");
`else
`define SCM_ASSERT(lbl, clk, rst_n, prop)
`define SCM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hw/rtl/scm_pkg.sv]
// Types, codes and byte helpers of the sequence command to MIDI encoder.
// Depends on nothing.
package scm_pkg;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIV, S_RET, S_DELTA, S_BODY, S_EMPTY
  } state_e;

  typedef enum logic [3:0] {
    EV_NOTE_OFF, EV_NOTE_ON, EV_BANK, EV_PROG, EV_RPN,
    EV_BEND, EV_CTRL, EV_TEMPO, EV_ALLOFF
  } event_e;

  // result status
  localparam logic [2:0] ST_CONT     = 3'd0;
  localparam logic [2:0] ST_REDIRECT = 3'd1;
  localparam logic [2:0] ST_FINISH   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;

  // sequence commands
  localparam logic [7:0] CMD_WAIT8  = 8'h80;
  localparam logic [7:0] CMD_WAIT16 = 8'h88;
  localparam logic [7:0] CMD_WAIT28 = 8'hF0;
  localparam logic [7:0] CMD_CALL   = 8'hC3;
  localparam logic [7:0] CMD_RET    = 8'hC5;
  localparam logic [7:0] CMD_PROG   = 8'hE3;
  localparam logic [7:0] CMD_FX8    = 8'hB8;
  localparam logic [7:0] CMD_FX16   = 8'hB9;
  localparam logic [7:0] CMD_TEMPO  = 8'hE0;
  localparam logic [7:0] CMD_END    = 8'hFF;
  localparam logic [7:0] CMD_NOP_A  = 8'hC7;
  localparam logic [7:0] CMD_NOP_B  = 8'hC1;
  localparam logic [7:0] CMD_NOP_C  = 8'hD8;
  localparam logic [7:0] CMD_NOP_D  = 8'hE2;
  localparam logic [7:0] CMD_NOP_E  = 8'hF9;

  // effect types
  localparam logic [7:0] FX_VOLUME = 8'd0;
  localparam logic [7:0] FX_PITCH  = 8'd1;
  localparam logic [7:0] FX_REVERB = 8'd2;
  localparam logic [7:0] FX_PAN    = 8'd3;

  // MIDI bytes
  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_CTRL     = 8'hB0;
  localparam logic [7:0] MIDI_PROG     = 8'hC0;
  localparam logic [7:0] MIDI_BEND     = 8'hE0;
  localparam logic [7:0] MIDI_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TEMPO_LEN = 8'h03;
  localparam logic [7:0] CC_BANK       = 8'h00;
  localparam logic [7:0] CC_VOLUME     = 8'h07;
  localparam logic [7:0] CC_REVERB     = 8'h5B;
  localparam logic [7:0] CC_PAN        = 8'h0A;
  localparam logic [7:0] CC_ALL_OFF    = 8'h7B;
  localparam logic [7:0] CC_RPN_LSB    = 8'h64;
  localparam logic [7:0] CC_RPN_MSB    = 8'h65;
  localparam logic [7:0] CC_DATA_MSB   = 8'h06;
  localparam logic [7:0] CC_DATA_LSB   = 8'h26;
  localparam logic [7:0] RPN_NULL      = 8'h7F;
  localparam logic [7:0] BEND_RANGE    = 8'h30;
  localparam logic [7:0] OFF_VELOCITY  = 8'h40;
  localparam logic [7:0] BANK_BASE     = 8'h16;
  localparam logic [13:0] BEND_CENTRE  = 14'h2000;
  localparam logic [25:0] USEC_PER_MIN = 26'd60000000;
  localparam logic [4:0]  DIV_LAST     = 5'd25;

  function automatic logic [4:0] body_len(event_e ev);
    logic [4:0] n;
    case (ev)
      EV_PROG:  n = 5'd2;
      EV_RPN:   n = 5'd23;
      EV_TEMPO: n = 5'd6;
      default:  n = 5'd3;
    endcase
    return n;
  endfunction

  // index of the most significant non-empty 7-bit group
  function automatic logic [2:0] vlq_top(logic [31:0] v);
    logic [2:0] t;
    if (v[31:28] != 4'd0)       t = 3'd4;
    else if (v[27:21] != 7'd0)  t = 3'd3;
    else if (v[20:14] != 7'd0)  t = 3'd2;
    else if (v[13:7] != 7'd0)   t = 3'd1;
    else                        t = 3'd0;
    return t;
  endfunction

  function automatic logic [7:0] vlq_byte(logic [31:0] v, logic [2:0] g);
    logic [6:0] b;
    case (g)
      3'd1:    b = v[13:7];
      3'd2:    b = v[20:14];
      3'd3:    b = v[27:21];
      3'd4:    b = {3'd0, v[31:28]};
      default: b = v[6:0];
    endcase
    return {(g != 3'd0), b};
  endfunction

  // pitch-bend range setup, s is the controller status of the channel
  function automatic logic [7:0] rpn_byte(logic [4:0] idx, logic [7:0] s);
    logic [7:0] b;
    case (idx)
      5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20: b = s;
      5'd1, 5'd17: b = CC_RPN_LSB;
      5'd5, 5'd21: b = CC_RPN_MSB;
      5'd9:        b = CC_DATA_MSB;
      5'd10:       b = BEND_RANGE;
      5'd13:       b = CC_DATA_LSB;
      5'd18, 5'd22: b = RPN_NULL;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/scm_ram.sv]
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module scm_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/sequence_command_to_midi_encoder_top.sv]
// Top level of the sequence command to MIDI byte encoder.
// Depends on scm_pkg, scm_ram and assert_macros.svh.
//
//  channel  | direction | tdata (low bit up)                          | tuser    | tlast
//  s_axis   | in        | command, arg_byte, operand, following_byte, | kind     | -
//           |           | return_address                              |          |
//  m_axis   | out       | out_byte, status, next_address              | has_byte | last
//
// A request is taken in an idle cycle and decoded in the next, then gives one
// MIDI byte a cycle while the output has room (up to 32); a tempo request first
// runs the restoring divider and a return first reads the return stack. A request
// with no bytes gives one empty result. Results leave through one output register,
// in the cycle after they are formed.
// Reset clears voices, timing, channel, channel count, pitch flag and stack count;
// the channel map and the return stack hold garbage until written. A stalled
// output holds the sequencer; s_axis_tready_o is high only while idle.
`include "assert_macros.svh"
module sequence_command_to_midi_encoder_top #(
  parameter int unsigned VOICES        = 8,
  parameter int unsigned CHANNEL_SLOTS = 16,
  parameter int unsigned STACK_DEPTH   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[7:0] arg_byte[15:8] operand[43:16] following_byte[51:44]
  // return_address[75:52] zero[79:76]
  input  logic [79:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_byte[7:0] status[10:8] next_address[34:11] zero[39:35]
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // has_byte
  output logic        m_axis_tlast_o    // last
);
  localparam int unsigned VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned SIW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(CHANNEL_SLOTS + 1);
  localparam int unsigned KAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned KW  = $clog2(STACK_DEPTH + 1);

  // control state
  scm_pkg::state_e state_q, state_d;
  scm_pkg::event_e ev_q, ev_d, ev2_q, ev2_d;
  logic        has2_q, has2_d;
  logic [2:0]  grp_q, grp_d;
  logic [4:0]  idx_q, idx_d;
  logic [2:0]  status_q, status_d;
  logic [23:0] next_q, next_d;
  logic [6:0]  voice_q [VOICES];
  logic [6:0]  voice_d [VOICES];
  logic [31:0] delta_q, delta_d;
  logic [3:0]  chan_q, chan_d;
  logic [CW-1:0] chan_cnt_q, chan_cnt_d;
  logic        pitch_rdy_q, pitch_rdy_d;
  logic [KW-1:0] stk_cnt_q, stk_cnt_d;

  // payload
  logic [7:0]  prog_q [CHANNEL_SLOTS];
  logic [7:0]  prog_d [CHANNEL_SLOTS];
  logic        pflag_q [CHANNEL_SLOTS];
  logic        pflag_d [CHANNEL_SLOTS];
  logic        kind_q;
  logic [7:0]  cmd_q, arg_q, follow_q;
  logic [27:0] opnd_q;
  logic [23:0] ret_q;
  logic [6:0]  off_note_q, off_note_d;
  logic [25:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [4:0]  dcnt_q, dcnt_d;

  // output register
  logic        ovld_q, ovld_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        ohas_q, ohas_d, olast_q, olast_d;
  logic [2:0]  ostat_q, ostat_d;
  logic [23:0] onext_q, onext_d;

  logic accept, room, emit, e_has, e_last;
  logic [7:0] e_byte;

  // searches
  logic hit_found, free_found, ch_found;
  logic [VIW-1:0] hit_idx, free_idx;
  logic [SIW-1:0] ch_idx;
  logic [6:0] voice_mod [VOICES];
  logic [3:0] voff;

  // stack RAM
  logic stk_we, stk_re;
  logic [KW-1:0] stk_dec;
  logic [23:0] stk_rdata;

  // body byte helpers
  logic [15:0] fx_val;
  logic [16:0] bend_adj;
  logic [16:0] bend_q17;
  logic [13:0] bend;
  logic [7:0]  cc_sel;
  logic        cc_ok;
  logic [7:0]  body_byte;
  logic [16:0] div_trial;

  assign s_axis_tready_o = (state_q == scm_pkg::S_IDLE);
  assign accept  = s_axis_tvalid_i & s_axis_tready_o;
  assign room    = ~ovld_q | m_axis_tready_i;
  assign stk_dec = stk_cnt_q - 1'b1;
  assign voff    = {1'b0, cmd_q[2:0]} - 4'd1;

  // Voice searches: retrigger hit first, then free slot on the updated set.
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!hit_found && voice_q[v] == cmd_q[6:0]) begin
        hit_found = 1'b1;
        hit_idx   = VIW'(v);
      end
    end
    for (int v = 0; v < VOICES; v++) begin
      voice_mod[v] = (hit_found && hit_idx == VIW'(v)) ? 7'd0 : voice_q[v];
    end
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!free_found && voice_mod[v] == 7'd0) begin
        free_found = 1'b1;
        free_idx   = VIW'(v);
      end
    end
  end

  // Channel map search over the slots in use, skipping pitch-marked ones.
  always_comb begin
    ch_found = 1'b0;
    ch_idx   = '0;
    for (int i = 0; i < CHANNEL_SLOTS; i++) begin
      if (!ch_found && i < int'(chan_cnt_q) && prog_q[i] == arg_q && !pflag_q[i]) begin
        ch_found = 1'b1;
        ch_idx   = SIW'(i);
      end
    end
  end

  // Effect value and pitch-bend word: divide by four towards zero, recentre.
  always_comb begin
    fx_val   = (cmd_q == scm_pkg::CMD_FX8) ? {{8{opnd_q[7]}}, opnd_q[7:0]} : opnd_q[15:0];
    bend_adj = {fx_val[15], fx_val} + (fx_val[15] ? 17'd3 : 17'd0);
    bend_q17 = 17'($signed(bend_adj) >>> 2);
    // the quotient never exceeds the centre, so the centre is always added
    bend     = bend_q17[13:0] + scm_pkg::BEND_CENTRE;
    cc_ok    = 1'b1;
    case (arg_q)
      scm_pkg::FX_VOLUME: cc_sel = scm_pkg::CC_VOLUME;
      scm_pkg::FX_REVERB: cc_sel = scm_pkg::CC_REVERB;
      scm_pkg::FX_PAN:    cc_sel = scm_pkg::CC_PAN;
      default: begin
        cc_sel = scm_pkg::CC_VOLUME;
        cc_ok  = 1'b0;
      end
    endcase
  end

  // Byte idx_q of the current event after its delta.
  always_comb begin
    body_byte = 8'h00;
    case (ev_q)
      scm_pkg::EV_NOTE_OFF: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_NOTE_OFF | {4'h0, chan_q};
          5'd1:    body_byte = {1'b0, off_note_q};
          default: body_byte = scm_pkg::OFF_VELOCITY;
        endcase
      end
      scm_pkg::EV_NOTE_ON: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_NOTE_ON | {4'h0, chan_q};
          5'd1:    body_byte = {1'b0, cmd_q[6:0]};
          default: body_byte = arg_q;
        endcase
      end
      scm_pkg::EV_BANK: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_CTRL | {4'h0, chan_q};
          5'd1:    body_byte = scm_pkg::CC_BANK;
          default: body_byte = {7'd0, arg_q[7]} + scm_pkg::BANK_BASE;
        endcase
      end
      scm_pkg::EV_PROG: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_PROG | {4'h0, chan_q};
          default: body_byte = {1'b0, arg_q[6:0]};
        endcase
      end
      scm_pkg::EV_RPN: begin
        body_byte = scm_pkg::rpn_byte(idx_q, scm_pkg::MIDI_CTRL | {4'h0, chan_q});
      end
      scm_pkg::EV_BEND: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_BEND | {4'h0, chan_q};
          5'd1:    body_byte = {1'b0, bend[6:0]};
          default: body_byte = {1'b0, bend[13:7]};
        endcase
      end
      scm_pkg::EV_CTRL: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_CTRL | {4'h0, chan_q};
          5'd1:    body_byte = cc_sel;
          default: body_byte = opnd_q[7:0];
        endcase
      end
      scm_pkg::EV_TEMPO: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_META;
          5'd1:    body_byte = scm_pkg::META_TEMPO;
          5'd2:    body_byte = scm_pkg::META_TEMPO_LEN;
          5'd3:    body_byte = quo_q[23:16];
          5'd4:    body_byte = quo_q[15:8];
          default: body_byte = quo_q[7:0];
        endcase
      end
      scm_pkg::EV_ALLOFF: begin
        case (idx_q)
          5'd0:    body_byte = scm_pkg::MIDI_CTRL | {4'h0, chan_q};
          5'd1:    body_byte = scm_pkg::CC_ALL_OFF;
          default: body_byte = 8'h00;
        endcase
      end
      default: body_byte = 8'h00;
    endcase
  end

  assign div_trial = {rem_q, dvd_q[25]};

  // Sequencer: next state and all register updates.
  always_comb begin
    state_d     = state_q;
    ev_d        = ev_q;
    ev2_d       = ev2_q;
    has2_d      = has2_q;
    grp_d       = grp_q;
    idx_d       = idx_q;
    status_d    = status_q;
    next_d      = next_q;
    voice_d     = voice_q;
    delta_d     = delta_q;
    chan_d      = chan_q;
    chan_cnt_d  = chan_cnt_q;
    pitch_rdy_d = pitch_rdy_q;
    stk_cnt_d   = stk_cnt_q;
    prog_d      = prog_q;
    pflag_d     = pflag_q;
    off_note_d  = off_note_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    emit        = 1'b0;
    e_has       = 1'b1;
    e_byte      = 8'h00;
    e_last      = 1'b0;

    case (state_q)
      scm_pkg::S_IDLE: begin
        if (accept) begin
          state_d  = scm_pkg::S_DECODE;
          status_d = scm_pkg::ST_CONT;
          next_d   = '0;
          has2_d   = 1'b0;
          idx_d    = '0;
        end
      end

      scm_pkg::S_DECODE: begin
        state_d = scm_pkg::S_EMPTY;
        grp_d   = scm_pkg::vlq_top(delta_q);
        if (kind_q) begin
          ev_d        = scm_pkg::EV_ALLOFF;
          state_d     = scm_pkg::S_DELTA;
          pitch_rdy_d = 1'b0;
        end else if (!cmd_q[7]) begin
          // note-on: turn off a sounding copy first, then take a free voice
          if (hit_found) begin
            voice_d[hit_idx] = 7'd0;
            off_note_d = cmd_q[6:0];
            ev_d       = scm_pkg::EV_NOTE_OFF;
            state_d    = scm_pkg::S_DELTA;
            if (free_found) begin
              ev2_d  = scm_pkg::EV_NOTE_ON;
              has2_d = 1'b1;
            end
          end else if (free_found) begin
            ev_d    = scm_pkg::EV_NOTE_ON;
            state_d = scm_pkg::S_DELTA;
          end
          if (free_found) begin
            voice_d[free_idx] = cmd_q[6:0];
          end
        end else if (cmd_q == scm_pkg::CMD_WAIT8) begin
          delta_d = delta_q + {24'd0, opnd_q[7:0]};
        end else if (cmd_q < scm_pkg::CMD_WAIT16) begin
          if (int'(cmd_q[2:0]) <= VOICES) begin
            off_note_d = voice_q[voff[VIW-1:0]];
            voice_d[voff[VIW-1:0]] = 7'd0;
            ev_d    = scm_pkg::EV_NOTE_OFF;
            state_d = scm_pkg::S_DELTA;
          end
        end else begin
          case (cmd_q)
            scm_pkg::CMD_WAIT16: delta_d = delta_q + {16'd0, opnd_q[15:0]};
            scm_pkg::CMD_WAIT28: delta_d = delta_q + {4'd0, opnd_q};
            scm_pkg::CMD_NOP_A, scm_pkg::CMD_NOP_B, scm_pkg::CMD_NOP_C,
            scm_pkg::CMD_NOP_D, scm_pkg::CMD_NOP_E: begin
            end
            scm_pkg::CMD_CALL: begin
              if (stk_cnt_q >= KW'(STACK_DEPTH)) begin
                status_d = scm_pkg::ST_ERROR;
              end else begin
                stk_we    = 1'b1;
                stk_cnt_d = stk_cnt_q + 1'b1;
                status_d  = scm_pkg::ST_REDIRECT;
                next_d    = opnd_q[23:0];
              end
            end
            scm_pkg::CMD_RET: begin
              if (stk_cnt_q != '0) begin
                stk_re    = 1'b1;
                stk_cnt_d = stk_dec;
                status_d  = scm_pkg::ST_REDIRECT;
                state_d   = scm_pkg::S_RET;
              end
            end
            scm_pkg::CMD_PROG: begin
              if (follow_q != scm_pkg::CMD_PROG) begin
                if (ch_found) begin
                  chan_d  = 4'(ch_idx);
                  ev_d    = scm_pkg::EV_BANK;
                  ev2_d   = scm_pkg::EV_PROG;
                  has2_d  = 1'b1;
                  state_d = scm_pkg::S_DELTA;
                end else if (chan_cnt_q >= CW'(CHANNEL_SLOTS)) begin
                  status_d = scm_pkg::ST_ERROR;
                end else begin
                  prog_d[chan_cnt_q[SIW-1:0]]  = arg_q;
                  pflag_d[chan_cnt_q[SIW-1:0]] = 1'b0;
                  chan_cnt_d = chan_cnt_q + 1'b1;
                  chan_d     = 4'(chan_cnt_q[SIW-1:0]);
                  ev_d       = scm_pkg::EV_BANK;
                  ev2_d      = scm_pkg::EV_PROG;
                  has2_d     = 1'b1;
                  state_d    = scm_pkg::S_DELTA;
                end
              end
            end
            scm_pkg::CMD_FX8, scm_pkg::CMD_FX16: begin
              if (arg_q == scm_pkg::FX_PITCH) begin
                state_d = scm_pkg::S_DELTA;
                if (!pitch_rdy_q) begin
                  ev_d        = scm_pkg::EV_RPN;
                  ev2_d       = scm_pkg::EV_BEND;
                  has2_d      = 1'b1;
                  pitch_rdy_d = 1'b1;
                  if (int'(chan_q) < int'(chan_cnt_q)) begin
                    pflag_d[chan_q[SIW-1:0]] = 1'b1;
                  end
                end else begin
                  ev_d = scm_pkg::EV_BEND;
                end
              end else if (cc_ok) begin
                ev_d    = scm_pkg::EV_CTRL;
                state_d = scm_pkg::S_DELTA;
              end
            end
            scm_pkg::CMD_TEMPO: begin
              if (opnd_q[15:0] == 16'd0) begin
                status_d = scm_pkg::ST_ERROR;
              end else begin
                dvd_d   = scm_pkg::USEC_PER_MIN;
                rem_d   = '0;
                quo_d   = '0;
                dcnt_d  = scm_pkg::DIV_LAST;
                ev_d    = scm_pkg::EV_TEMPO;
                state_d = scm_pkg::S_DIV;
              end
            end
            scm_pkg::CMD_END: status_d = scm_pkg::ST_FINISH;
            default:          status_d = scm_pkg::ST_UNKNOWN;
          endcase
        end
      end

      // one quotient bit a cycle, most significant first
      scm_pkg::S_DIV: begin
        dvd_d = {dvd_q[24:0], 1'b0};
        if (div_trial >= {1'b0, opnd_q[15:0]}) begin
          rem_d = 16'(div_trial - {1'b0, opnd_q[15:0]});
          quo_d = {quo_q[24:0], 1'b1};
        end else begin
          rem_d = div_trial[15:0];
          quo_d = {quo_q[24:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd0) begin
          state_d = scm_pkg::S_DELTA;
        end
      end

      scm_pkg::S_RET: begin
        next_d  = stk_rdata;
        state_d = scm_pkg::S_EMPTY;
      end

      scm_pkg::S_DELTA: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = scm_pkg::vlq_byte(delta_q, grp_q);
          if (grp_q == 3'd0) begin
            delta_d = '0;
            idx_d   = '0;
            state_d = scm_pkg::S_BODY;
          end else begin
            grp_d = grp_q - 1'b1;
          end
        end
      end

      scm_pkg::S_BODY: begin
        if (room) begin
          emit   = 1'b1;
          e_byte = body_byte;
          if (idx_q == scm_pkg::body_len(ev_q) - 5'd1) begin
            e_last = ~has2_q;
            if (has2_q) begin
              ev_d    = ev2_q;
              has2_d  = 1'b0;
              grp_d   = scm_pkg::vlq_top(delta_q);
              state_d = scm_pkg::S_DELTA;
            end else begin
              state_d = scm_pkg::S_IDLE;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      scm_pkg::S_EMPTY: begin
        if (room) begin
          emit    = 1'b1;
          e_has   = 1'b0;
          e_last  = 1'b1;
          state_d = scm_pkg::S_IDLE;
        end
      end

      default: state_d = scm_pkg::S_IDLE;
    endcase
  end

  // Output register: drop on take, load on emit.
  always_comb begin
    ovld_d  = ovld_q & ~m_axis_tready_i;
    obyte_d = obyte_q;
    ohas_d  = ohas_q;
    olast_d = olast_q;
    ostat_d = ostat_q;
    onext_d = onext_q;
    if (emit) begin
      ovld_d  = 1'b1;
      obyte_d = e_byte;
      ohas_d  = e_has;
      olast_d = e_last;
      ostat_d = status_q;
      onext_d = next_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scm_pkg::S_IDLE;
      ev_q        <= scm_pkg::EV_NOTE_OFF;
      ev2_q       <= scm_pkg::EV_NOTE_OFF;
      has2_q      <= 1'b0;
      grp_q       <= '0;
      idx_q       <= '0;
      status_q    <= scm_pkg::ST_CONT;
      next_q      <= '0;
      voice_q     <= '{default: 7'd0};
      delta_q     <= '0;
      chan_q      <= '0;
      chan_cnt_q  <= '0;
      pitch_rdy_q <= 1'b0;
      stk_cnt_q   <= '0;
      dcnt_q      <= '0;
      ovld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ev_q        <= ev_d;
      ev2_q       <= ev2_d;
      has2_q      <= has2_d;
      grp_q       <= grp_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      next_q      <= next_d;
      voice_q     <= voice_d;
      delta_q     <= delta_d;
      chan_q      <= chan_d;
      chan_cnt_q  <= chan_cnt_d;
      pitch_rdy_q <= pitch_rdy_d;
      stk_cnt_q   <= stk_cnt_d;
      dcnt_q      <= dcnt_d;
      ovld_q      <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= s_axis_tuser_i;
      cmd_q    <= s_axis_tdata_i[7:0];
      arg_q    <= s_axis_tdata_i[15:8];
      opnd_q   <= s_axis_tdata_i[43:16];
      follow_q <= s_axis_tdata_i[51:44];
      ret_q    <= s_axis_tdata_i[75:52];
    end
    prog_q     <= prog_d;
    pflag_q    <= pflag_d;
    off_note_q <= off_note_d;
    dvd_q      <= dvd_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    obyte_q    <= obyte_d;
    ohas_q     <= ohas_d;
    olast_q    <= olast_d;
    ostat_q    <= ostat_d;
    onext_q    <= onext_d;
  end

  scm_ram #(
    .WIDTH (24),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_cnt_q[KAW-1:0]),
    .wdata_i (ret_q),
    .re_i    (stk_re),
    .raddr_i (stk_dec[KAW-1:0]),
    .rdata_o (stk_rdata)
  );

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {5'd0, onext_q, ostat_q, obyte_q};
  assign m_axis_tuser_o  = ohas_q;
  assign m_axis_tlast_o  = olast_q;

  `SCM_NEVER(a_stack_bound, clk_i, rst_ni, stk_cnt_q > KW'(STACK_DEPTH))
  `SCM_NEVER(a_chan_bound, clk_i, rst_ni, chan_cnt_q > CW'(CHANNEL_SLOTS))
  `SCM_ASSERT(a_body_idx, clk_i, rst_ni, (state_q == scm_pkg::S_BODY) |-> (idx_q < scm_pkg::body_len(ev_q)))
  `SCM_ASSERT(a_delta_grp, clk_i, rst_ni, (state_q == scm_pkg::S_DELTA) |-> (grp_q <= 3'd4))
  `SCM_ASSERT(a_empty_last, clk_i, rst_ni, (ovld_q && !ohas_q) |-> olast_q)
endmodule
